FILE: rtl/mbrtu_pkg.sv
// package for the modbus rtu register read slave
// types, constants and crc helper used by the datapath, controller and top level; no dependencies
`default_nettype none
package mbrtu_pkg;
	localparam int MAX_BLOCKS    = 4;
	localparam int REG_MEM_DEPTH = 256;
	localparam int REQUEST_LEN   = 8;
	localparam int MEM_AW        = $clog2(REG_MEM_DEPTH);
	localparam int BLK_W         = $clog2(MAX_BLOCKS);
	localparam logic [6:0] MAX_QTY = 7'd125;

	localparam logic [1:0] CMD_RX_BYTE = 2'd0;
	localparam logic [1:0] CMD_DESC    = 2'd1;
	localparam logic [1:0] CMD_MEM     = 2'd2;

	localparam logic [7:0] EXC_FUNCTION = 8'h01;
	localparam logic [7:0] EXC_ADDRESS  = 8'h02;
	localparam logic [7:0] EXC_FAILURE  = 8'h07;
	localparam logic [7:0] FC_HOLDING   = 8'h03;
	localparam logic [7:0] FC_INPUT     = 8'h04;
	localparam logic [7:0] EXC_FLAG     = 8'h80;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;

	localparam logic [0:0] CFG_SLAVE_ADDRESS = 1'd0;
	localparam logic [0:0] CFG_BLOCKS_IN_USE = 1'd1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  rx_byte;
		logic        rx_more;
		logic [1:0]  desc_index;
		logic [7:0]  desc_function;
		logic [15:0] desc_start;
		logic [15:0] desc_length;
		logic [7:0]  desc_base;
		logic [7:0]  mem_index;
		logic [15:0] mem_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] tx_bytes;
		logic [2:0]  tx_count;
		logic        tx_last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] index;
		logic [7:0] data;
	} cfg_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CRC, ST_CHECK, ST_SEARCH, ST_EXC, ST_HDR,
		ST_RD, ST_RDW, ST_TAIL, ST_EMIT
	} state_t;

	// byte source selected by the controller for the output packer
	typedef enum logic [2:0] {
		SRC_ADDR, SRC_FUNC, SRC_COUNT, SRC_EXC, SRC_HI, SRC_LO, SRC_CRC_LO, SRC_CRC_HI
	} src_t;

	typedef struct packed {
		logic       crc_start;
		logic       crc_req_step;
		logic       push;
		src_t       src;
		logic       emit;
		logic       emit_last;
		logic       set_exc;
		logic [7:0] exc_code;
		logic       load_func;
		logic       blk_clr;
		logic       blk_step;
		logic       rd_start;
		logic       rd_step;
	} ctl_t;

	typedef struct packed {
		logic       crc_done;
		logic       addr_match;
		logic       func_ok;
		logic       crc_ok;
		logic       blk_done;
		logic       blk_found;
		logic       blk_fit;
		logic       rd_done;
		logic       pack_full;
		logic       pack_empty;
		logic       out_busy;
	} sts_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/mbrtu_if.sv
// valid/ready channel interface with source and sink modports
// depends on nothing; payload type given per instance
`default_nettype none
interface mbrtu_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/mbrtu_ram.sv
// generic single-port write, registered read ram
// no dependencies
`default_nettype none
module mbrtu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/mbrtu_datapath.sv
// datapath: request buffer, descriptors, crc, block search, memory read, byte packer
// depends on mbrtu_pkg and mbrtu_ram
`default_nettype none
module mbrtu_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mbrtu_pkg::in_item_t  in_item,
	input  wire logic                 in_take,
	input  wire logic [7:0]           slave_address,
	input  wire logic [2:0]           blocks_in_use,
	input  wire mbrtu_pkg::ctl_t      ctl,
	output mbrtu_pkg::sts_t           sts,
	output logic                      req_ready,
	output logic                      req_more,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output mbrtu_pkg::out_item_t      out_item
);
	import mbrtu_pkg::*;

	logic [7:0]  req_q [REQUEST_LEN];
	logic [2:0]  rx_count_q;
	logic        more_q, rdy_q;
	logic [7:0]  func_q;
	logic [7:0]  bf_q [MAX_BLOCKS];
	logic [15:0] bs_q [MAX_BLOCKS];
	logic [15:0] bl_q [MAX_BLOCKS];
	logic [7:0]  bb_q [MAX_BLOCKS];
	logic [15:0] crc_q;
	logic [2:0]  ci_q;
	logic        crc_done_q;
	logic [BLK_W:0] bi_q;
	logic        found_q, fit_q, bdone_q;
	logic [15:0] off_q;
	logic [7:0]  base_q;
	logic [6:0]  rcnt_q;
	logic [MEM_AW-1:0] raddr_q;
	logic [15:0] rdata;
	logic [31:0] pb_q;
	logic [2:0]  pn_q;
	logic        ov_q;
	out_item_t   oi_q;

	logic [15:0] addr, qty;
	logic [2:0]  nb;
	logic [BLK_W-1:0] bx;
	logic [16:0] rel;
	logic [7:0]  pbyte;
	logic        rx_ev;

	assign addr = {req_q[2], req_q[3]};
	assign qty  = {req_q[4], req_q[5]};
	assign nb   = (blocks_in_use > 3'(MAX_BLOCKS)) ? 3'(MAX_BLOCKS) : blocks_in_use;
	assign bx   = bi_q[BLK_W-1:0];
	assign rel  = {1'b0, addr} - {1'b0, bs_q[bx]};
	assign rx_ev = in_take && in_item.cmd == CMD_RX_BYTE;

	mbrtu_ram #(.WIDTH(16), .DEPTH(REG_MEM_DEPTH)) u_ram (
		.clk(clk),
		.we(in_take && in_item.cmd == CMD_MEM),
		.waddr(in_item.mem_index[MEM_AW-1:0]),
		.wdata(in_item.mem_value),
		.raddr(raddr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q <= '0;
			rdy_q <= 1'b0;
			func_q <= '0;
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				bf_q[i] <= '0; bs_q[i] <= '0; bl_q[i] <= '0; bb_q[i] <= '0;
			end
			crc_done_q <= 1'b0;
			bdone_q <= 1'b0;
			found_q <= 1'b0;
			pn_q <= '0;
			ov_q <= 1'b0;
		end else begin
			rdy_q <= rx_ev && rx_count_q == 3'(REQUEST_LEN - 1);
			if (rx_ev) begin
				req_q[rx_count_q] <= in_item.rx_byte;
				rx_count_q <= rx_count_q + 3'd1;
				if (rx_count_q == 3'(REQUEST_LEN - 1)) more_q <= in_item.rx_more;
			end
			if (in_take && in_item.cmd == CMD_DESC && 32'(in_item.desc_index) < MAX_BLOCKS) begin
				bf_q[in_item.desc_index[BLK_W-1:0]] <= in_item.desc_function;
				bs_q[in_item.desc_index[BLK_W-1:0]] <= in_item.desc_start;
				bl_q[in_item.desc_index[BLK_W-1:0]] <= in_item.desc_length;
				bb_q[in_item.desc_index[BLK_W-1:0]] <= in_item.desc_base;
			end
			// crc over six request bytes, one byte a cycle, then over each pushed response byte
			if (ctl.crc_start) begin
				crc_q <= CRC_INIT; ci_q <= '0; crc_done_q <= 1'b0;
			end else if (ctl.crc_req_step && !crc_done_q) begin
				crc_q <= crc_byte(crc_q, req_q[ci_q]);
				ci_q <= ci_q + 3'd1;
				if (ci_q == 3'd5) crc_done_q <= 1'b1;
			end else if (ctl.push && !(ctl.src inside {SRC_CRC_LO, SRC_CRC_HI})) begin
				// the crc bytes themselves are not folded in
				crc_q <= crc_byte(crc_q, pbyte);
			end
			if (ctl.load_func) func_q <= req_q[1];
			if (ctl.set_exc) func_q <= func_q | EXC_FLAG;
			// block search, one descriptor a cycle
			if (ctl.blk_clr) begin
				bi_q <= '0; found_q <= 1'b0; bdone_q <= (nb == 3'd0);
			end else if (ctl.blk_step && !bdone_q) begin
				if (bf_q[bx] == func_q && !rel[16] && rel[15:0] < bl_q[bx]) begin
					found_q <= 1'b1;
					bdone_q <= 1'b1;
					fit_q <= qty <= 16'(MAX_QTY) && qty <= bl_q[bx] - rel[15:0];
					off_q <= rel[15:0];
					base_q <= bb_q[bx];
				end else begin
					bi_q <= bi_q + 1'b1;
					if (3'(bi_q) + 3'd1 >= nb) bdone_q <= 1'b1;
				end
			end
			if (ctl.rd_start) begin
				raddr_q <= MEM_AW'(32'(base_q) + 32'(off_q));
				rcnt_q <= qty[6:0];
			end else if (ctl.rd_step) begin
				raddr_q <= raddr_q + 1'b1;
				rcnt_q <= rcnt_q - 7'd1;
			end
			if (ctl.crc_start) pn_q <= '0;
			// byte packer and output register
			if (out_valid && out_ready) ov_q <= 1'b0;
			if (ctl.push) begin
				pb_q[8*pn_q[1:0] +: 8] <= pbyte;
				pn_q <= pn_q + 3'd1;
			end
			if (ctl.emit) begin
				ov_q <= 1'b1;
				for (int k = 0; k < 4; k++)
					oi_q.tx_bytes[8*k +: 8] <= (3'(k) < pn_q) ? pb_q[8*k +: 8] : 8'h00;
				oi_q.tx_count <= pn_q;
				oi_q.tx_last <= ctl.emit_last;
				pn_q <= '0;
			end
		end
	end

	always_comb begin
		case (ctl.src)
			SRC_ADDR:   pbyte = slave_address;
			SRC_FUNC:   pbyte = func_q;
			SRC_COUNT:  pbyte = {qty[6:0], 1'b0};
			SRC_EXC:    pbyte = ctl.exc_code;
			SRC_HI:     pbyte = rdata[15:8];
			SRC_LO:     pbyte = rdata[7:0];
			SRC_CRC_LO: pbyte = crc_q[7:0];
			SRC_CRC_HI: pbyte = crc_q[15:8];
			default:    pbyte = 8'h00;
		endcase
	end

	assign req_ready = rdy_q;
	assign req_more  = more_q;
	assign out_valid = ov_q;
	assign out_item  = oi_q;
	assign sts.crc_done   = crc_done_q;
	assign sts.addr_match = req_q[0] == slave_address;
	assign sts.func_ok    = req_q[1] == FC_HOLDING || req_q[1] == FC_INPUT;
	assign sts.crc_ok     = crc_q == {req_q[7], req_q[6]};
	assign sts.blk_done   = bdone_q;
	assign sts.blk_found  = found_q;
	assign sts.blk_fit    = fit_q;
	assign sts.rd_done    = rcnt_q == 7'd0;
	assign sts.pack_full  = pn_q == 3'd4;
	assign sts.pack_empty = pn_q == 3'd0;
	assign sts.out_busy   = ov_q;
endmodule
`default_nettype wire

FILE: rtl/mbrtu_ctrl.sv
// controller state machine for request checking and response sequencing
// depends on mbrtu_pkg
`default_nettype none
module mbrtu_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_ready,
	input  wire logic            req_more,
	input  wire mbrtu_pkg::sts_t sts,
	output mbrtu_pkg::ctl_t      ctl,
	output logic                 idle
);
	import mbrtu_pkg::*;

	state_t st_q, st_d;
	logic [2:0] step_q, step_d;
	logic [7:0] exc_q, exc_d;
	logic lo_q, lo_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; step_q <= '0; exc_q <= '0; lo_q <= 1'b0;
		end else begin
			st_q <= st_d; step_q <= step_d; exc_q <= exc_d; lo_q <= lo_d;
		end
	end

	always_comb begin
		st_d = st_q; step_d = step_q; exc_d = exc_q; lo_d = lo_q;
		ctl = '0;
		ctl.src = SRC_ADDR;
		ctl.exc_code = exc_q;
		idle = st_q == ST_IDLE;
		case (st_q)
			ST_IDLE: if (req_ready) begin
				ctl.crc_start = 1'b1;
				if (!sts.addr_match) st_d = ST_IDLE;
				else if (req_more) begin
					exc_d = EXC_FAILURE; st_d = ST_EXC;
				end else begin
					ctl.load_func = 1'b1;
					if (!sts.func_ok) begin
						exc_d = EXC_FUNCTION; st_d = ST_EXC;
					end else st_d = ST_CRC;
				end
			end
			ST_CRC: begin
				ctl.crc_req_step = 1'b1;
				if (sts.crc_done) st_d = ST_CHECK;
			end
			ST_CHECK: begin
				ctl.blk_clr = 1'b1;
				if (!sts.crc_ok) begin
					exc_d = EXC_FAILURE; st_d = ST_EXC;
				end else st_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				ctl.blk_step = 1'b1;
				if (sts.blk_done) begin
					if (sts.blk_found && sts.blk_fit) begin
						ctl.crc_start = 1'b1; ctl.rd_start = 1'b1;
						step_d = '0; st_d = ST_HDR;
					end else begin
						ctl.crc_start = 1'b1; exc_d = EXC_ADDRESS; st_d = ST_EXC;
					end
				end
			end
			ST_EXC: begin
				// restart crc on the way in; push addr, func|80, code
				if (step_q == 3'd0) begin
					ctl.crc_start = 1'b1; ctl.set_exc = 1'b1; step_d = 3'd1;
				end else begin
					ctl.push = 1'b1;
					ctl.src = (step_q == 3'd1) ? SRC_ADDR : (step_q == 3'd2) ? SRC_FUNC : SRC_EXC;
					step_d = step_q + 3'd1;
					if (step_q == 3'd3) begin
						step_d = '0; st_d = ST_TAIL;
					end
				end
			end
			ST_HDR: begin
				ctl.push = 1'b1;
				ctl.src = (step_q == 3'd0) ? SRC_ADDR : (step_q == 3'd1) ? SRC_FUNC : SRC_COUNT;
				step_d = step_q + 3'd1;
				if (step_q == 3'd2) begin
					step_d = '0; st_d = ST_RD;
				end
			end
			ST_RD: begin
				// read data appears the cycle after the address settles
				if (sts.rd_done) st_d = ST_TAIL;
				else begin
					lo_d = 1'b0; st_d = ST_RDW;
				end
			end
			ST_RDW: begin
				if (sts.pack_full) begin
					if (!sts.out_busy) ctl.emit = 1'b1;
				end else begin
					ctl.push = 1'b1;
					ctl.src = lo_q ? SRC_LO : SRC_HI;
					lo_d = !lo_q;
					if (lo_q) begin
						ctl.rd_step = 1'b1; st_d = ST_RD;
					end
				end
			end
			ST_TAIL: begin
				if (sts.pack_full) begin
					if (!sts.out_busy) ctl.emit = 1'b1;
				end else begin
					ctl.push = 1'b1;
					ctl.src = (step_q == 3'd0) ? SRC_CRC_LO : SRC_CRC_HI;
					step_d = step_q + 3'd1;
					if (step_q == 3'd1) begin
						step_d = '0; st_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					if (sts.pack_empty) st_d = ST_IDLE;
					else begin
						ctl.emit = 1'b1; ctl.emit_last = 1'b1; st_d = ST_IDLE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/modbus_rtu_register_read_slave_unit.sv
// top level of the modbus rtu read-registers slave
// depends on mbrtu_pkg, mbrtu_if, mbrtu_ctrl, mbrtu_datapath, mbrtu_ram
`default_nettype none
// Modbus RTU slave answering function codes 3 and 4. Input items carry a
// received byte, a block descriptor write or a register memory write.
// On the eighth request byte the controller checks address, pending
// bytes, function and CRC (the CRC runs one byte per cycle), searches
// descriptors one per cycle, then reads the register memory word by word,
// high byte first, and packs response bytes four to a result. Each result
// waits until the output register is empty. A response carries at most
// 125 registers. No item is taken while a response is being built.
// Results leave through a registered output, so the next result is built
// while one waits.
module modbus_rtu_register_read_slave_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	mbrtu_if.sink     in_ch,
	mbrtu_if.source   out_ch,
	mbrtu_if.sink     cfg_ch
);
	import mbrtu_pkg::*;

	logic [7:0] slave_address_q;
	logic [2:0] blocks_in_use_q;
	ctl_t ctl;
	sts_t sts;
	logic idle, req_ready, req_more, in_take;

	// items are taken only when the controller is idle and no request is pending
	assign in_ch.ready = idle && !req_ready;
	assign in_take = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'd1;
			blocks_in_use_q <= '0;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.data.index == 8'(CFG_SLAVE_ADDRESS)) slave_address_q <= cfg_ch.data.data;
			if (cfg_ch.data.index == 8'(CFG_BLOCKS_IN_USE)) blocks_in_use_q <= cfg_ch.data.data[2:0];
		end
	end

	mbrtu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_ready(req_ready), .req_more(req_more),
		.sts(sts), .ctl(ctl), .idle(idle)
	);

	mbrtu_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_ch.data), .in_take(in_take),
		.slave_address(slave_address_q), .blocks_in_use(blocks_in_use_q),
		.ctl(ctl), .sts(sts), .req_ready(req_ready), .req_more(req_more),
		.out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_item(out_ch.data)
	);
endmodule
`default_nettype wire
